FILE: design/dafir_pkg.sv
// ----------------------------------------------------------------------------
// dafir_pkg
// shared types and constants of the distributed arithmetic fir filter
// ----------------------------------------------------------------------------
package dafir_pkg;

    localparam int SAMPLE_W    = 16;
    localparam int COEF_W      = 16;
    localparam int OUT_W       = 35;
    localparam int NUM_COEF    = 8;
    localparam int COEF_IDX_W  = $clog2(NUM_COEF);
    localparam int APB_DATA_W  = 32;
    localparam int APB_ADDR_W  = COEF_IDX_W + 2;

    typedef logic signed [SAMPLE_W-1:0]   sample_t;
    typedef logic signed [COEF_W-1:0]     coef_t;
    typedef logic signed [OUT_W-1:0]      filtered_t;
    typedef logic [COEF_IDX_W-1:0]        coef_idx_t;
    typedef logic [APB_ADDR_W-1:0]        apb_addr_t;
    typedef logic [APB_DATA_W-1:0]        apb_data_t;

endpackage

FILE: design/dafir_stream_if.sv
// ----------------------------------------------------------------------------
// dafir stream interfaces
// valid/ready channels for input samples and filtered results
// ----------------------------------------------------------------------------
interface dafir_sample_if
    import dafir_pkg::*;
();
    logic    valid;
    logic    ready;
    sample_t sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface dafir_result_if
    import dafir_pkg::*;
();
    logic      valid;
    logic      ready;
    filtered_t filtered;

    modport source (output valid, output filtered, input ready);
    modport sink   (input valid, input filtered, output ready);
endinterface

FILE: design/da_fir_filter_core.sv
// ----------------------------------------------------------------------------
// da_fir_filter_core
// multiplierless fir filter using distributed arithmetic
//
// sample_ch takes one signed q1.15 word per valid/ready handshake; result_ch
// returns one q5.30 word per sample, in order. coefficients are written over
// the apb port (coef_k at byte address 4*k) and read back sign extended.
// each coefficient write rebuilds the 2^TAPS entry partial sum table, one
// entry per cycle, and sample_ch.ready is low while the sweep runs.
// the same sweep runs right after reset and clears the table.
// a sample walks its DATA_BITS bit slices through the single read port of
// the table, msb first, one slice per cycle, into the accumulator; a new
// sample is taken only once the previous result has left the accumulator.
// the finished word sits in an output register; the next sample is accepted
// while it waits, and its own result holds in the accumulator until the
// output register is free. reset clears the delay line, the coefficients and
// all valid flags.
// ----------------------------------------------------------------------------
module da_fir_filter_core
    import dafir_pkg::*;
#(
    parameter int TAPS      = 8,
    parameter int DATA_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    dafir_sample_if.sink          sample_ch,
    dafir_result_if.source        result_ch,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  apb_addr_t             paddr,
    input  apb_data_t             pwdata,
    output apb_data_t             prdata,
    output logic                  pready
);

    localparam int LUT_W     = COEF_W + $clog2(TAPS);
    localparam int LUT_DEPTH = 1 << TAPS;
    localparam int BIT_W     = $clog2(DATA_BITS);
    localparam int EXT_W     = (DATA_BITS > SAMPLE_W) ? DATA_BITS : SAMPLE_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_ISSUE = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_OUT   = 2'd3;

    localparam logic [BIT_W-1:0] MSB_BIT = BIT_W'(DATA_BITS - 1);

    // coefficient registers
    coef_t                   coef_reg [NUM_COEF];
    coef_idx_t               wr_idx;
    coef_idx_t               rd_idx;
    logic                    cfg_wr;

    // table rebuild sweep
    logic                    build_active_reg;
    logic                    build_active_next;
    logic [TAPS-1:0]         build_cnt_reg;
    logic [TAPS-1:0]         build_cnt_next;
    logic signed [LUT_W-1:0] build_sum;

    // table memory
    logic signed [LUT_W-1:0] lut_mem [LUT_DEPTH];
    logic signed [LUT_W-1:0] rd_word_reg;
    logic [TAPS-1:0]         rd_addr;

    // datapath
    logic [DATA_BITS-1:0]    delay_reg [TAPS];
    logic signed [EXT_W-1:0] sample_ext;
    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic [BIT_W-1:0]        bit_cnt_reg;
    logic [BIT_W-1:0]        bit_cnt_next;
    logic                    rd_valid_reg;
    logic                    rd_first_reg;
    filtered_t               acc_reg;
    filtered_t               acc_next;
    filtered_t               word_ext;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    filtered_t               filtered_reg;
    logic                    accept;
    logic                    out_load;

    // apb
    assign cfg_wr = psel && penable && pwrite;
    assign wr_idx = paddr[APB_ADDR_W-1:2];
    assign rd_idx = paddr[APB_ADDR_W-1:2];
    assign pready = 1'b1;
    assign prdata = APB_DATA_W'(coef_reg[rd_idx]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_COEF; i++)
            begin
                coef_reg[i] <= '0;
            end
        end
        else if (cfg_wr)
        begin
            coef_reg[wr_idx] <= pwdata[COEF_W-1:0];
        end
    end

    // partial sum of the coefficients selected by the sweep address
    always_comb
    begin
        build_sum = '0;
        for (int t = 0; t < TAPS; t++)
        begin
            if (build_cnt_reg[t])
            begin
                build_sum = build_sum + LUT_W'(coef_reg[t]);
            end
        end
    end

    always_comb
    begin
        build_active_next = build_active_reg;
        build_cnt_next    = build_cnt_reg;
        if (cfg_wr)
        begin
            build_active_next = 1'b1;
            build_cnt_next    = '0;
        end
        else if (build_active_reg)
        begin
            build_cnt_next = build_cnt_reg + 1'b1;
            if (&build_cnt_reg)
            begin
                build_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            build_active_reg <= 1'b1;
            build_cnt_reg    <= '0;
        end
        else
        begin
            build_active_reg <= build_active_next;
            build_cnt_reg    <= build_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (build_active_reg)
        begin
            lut_mem[build_cnt_reg] <= build_sum;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_word_reg <= lut_mem[rd_addr];
    end

    // one address bit per tap, taken from the current bit slice
    always_comb
    begin
        for (int t = 0; t < TAPS; t++)
        begin
            rd_addr[t] = delay_reg[t][bit_cnt_reg];
        end
    end

    // sample sign extends to the working word length where that is wider
    assign sample_ext = EXT_W'(sample_ch.sample);

    assign accept          = sample_ch.valid && sample_ch.ready;
    assign sample_ch.ready = (state_reg == ST_IDLE) && !build_active_reg;
    assign out_load        = (state_reg == ST_OUT) && (!out_valid_reg || result_ch.ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int t = 0; t < TAPS; t++)
            begin
                delay_reg[t] <= '0;
            end
        end
        else if (accept)
        begin
            delay_reg[0] <= sample_ext[DATA_BITS-1:0];
            for (int t = 1; t < TAPS; t++)
            begin
                delay_reg[t] <= delay_reg[t-1];
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        bit_cnt_next = bit_cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next   = ST_ISSUE;
                    bit_cnt_next = MSB_BIT;
                end
            end
            ST_ISSUE:
            begin
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    bit_cnt_next = bit_cnt_reg - 1'b1;
                end
            end
            ST_DRAIN:
            begin
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // msb slice carries negative weight, lower slices shift in below it
    assign word_ext = OUT_W'(rd_word_reg);

    always_comb
    begin
        acc_next = acc_reg;
        if (rd_valid_reg)
        begin
            if (rd_first_reg)
            begin
                acc_next = -word_ext;
            end
            else
            begin
                acc_next = {acc_reg[OUT_W-2:0], 1'b0} + word_ext;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (result_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            bit_cnt_reg   <= '0;
            rd_valid_reg  <= 1'b0;
            rd_first_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            bit_cnt_reg   <= bit_cnt_next;
            rd_valid_reg  <= (state_reg == ST_ISSUE);
            rd_first_reg  <= (state_reg == ST_ISSUE) && (bit_cnt_reg == MSB_BIT);
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        if (out_load)
        begin
            filtered_reg <= acc_reg;
        end
    end

    assign result_ch.valid    = out_valid_reg;
    assign result_ch.filtered = filtered_reg;

endmodule

FILE: verif/da_fir_filter_check.sv
// ----------------------------------------------------------------------------
// da_fir_filter_check
// watches the sample, result and apb ports of the da fir filter core, keeps
// its own copy of the coefficients and the tap delay line, predicts each
// filtered word and compares it with the words leaving the block, in order.
// coefficient read back over apb is checked against the written value.
// ----------------------------------------------------------------------------
module da_fir_filter_check
    import dafir_pkg::*;
#(
    parameter int TAPS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    dafir_sample_if   smp,
    dafir_result_if   res,
    input  logic      psel,
    input  logic      penable,
    input  logic      pwrite,
    input  logic      pready,
    input  apb_addr_t paddr,
    input  apb_data_t pwdata,
    input  apb_data_t prdata,
    output int        fail_count,
    output int        pending,
    output int        samples_seen,
    output int        results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    coef_t     coefs [NUM_COEF];
    sample_t   taps [TAPS];
    filtered_t filtered_due [$];

    function automatic filtered_t fir_sum();
        longint    acc;
        filtered_t sum;
        acc = 0;
        for (int t = 0; t < TAPS; t++)
        begin
            acc += longint'(coefs[t]) * longint'(taps[t]);
        end
        sum = acc[OUT_W-1:0];
        return sum;
    endfunction

    initial
    begin
        fail_count   = 0;
        pending      = 0;
        samples_seen = 0;
        results_seen = 0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        coef_idx_t idx;
        apb_data_t rd_exp;
        filtered_t want;
        if (!rst_n)
        begin
            foreach (coefs[i]) coefs[i] = '0;
            foreach (taps[i]) taps[i] = '0;
            filtered_due.delete();
            pending = 0;
        end
        else
        begin
            idx = paddr[APB_ADDR_W-1:2];
            if (psel && penable && pready && pwrite)
            begin
                coefs[idx] = pwdata[COEF_W-1:0];
            end
            if (psel && penable && pready && !pwrite)
            begin
                rd_exp = {{(APB_DATA_W-COEF_W){coefs[idx][COEF_W-1]}}, coefs[idx]};
                if (prdata !== rd_exp)
                begin
                    $error("prdata mismatch on coef_%0d: expected %h, actual %h",
                           idx, rd_exp, prdata);
                    fail_count++;
                end
            end
            if (res.valid === 1'b1 && res.ready === 1'b1)
            begin
                results_seen++;
                if (filtered_due.size() == 0)
                begin
                    $error("filtered word %0d arrived with no sample pending", res.filtered);
                    fail_count++;
                end
                else
                begin
                    want = filtered_due.pop_front();
                    if (res.filtered !== want)
                    begin
                        $error("filtered mismatch: expected %0d, actual %0d",
                               want, res.filtered);
                        fail_count++;
                    end
                end
            end
            if (smp.valid === 1'b1 && smp.ready === 1'b1)
            begin
                samples_seen++;
                for (int t = TAPS - 1; t > 0; t--)
                begin
                    taps[t] = taps[t-1];
                end
                taps[0] = smp.sample;
                filtered_due.push_back(fir_sum());
            end
            pending = filtered_due.size();
        end
    end

endmodule

FILE: verif/da_fir_filter_core_test.sv
// ----------------------------------------------------------------------------
// da_fir_filter_core_test
// drives samples and coefficient settings into the da fir filter core and
// lets the checker predict and compare every filtered word. a directed part
// covers reset coefficients, full scale taps and an impulse, then random
// phases with fresh coefficients each, random gaps on both sides, a long
// result stall and a full drain in the middle of a phase.
// ----------------------------------------------------------------------------
module da_fir_filter_core_test
    import dafir_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TAPS       = 8;
    localparam int DATA_BITS  = 16;
    localparam int RAND_PHASES = 8;
    localparam int PHASE_ITEMS = 91;
    localparam int DRAIN_CYCLES = DATA_BITS + 8;

    logic      clk;
    logic      rst_n;
    logic      psel;
    logic      penable;
    logic      pwrite;
    apb_addr_t paddr;
    apb_data_t pwdata;
    apb_data_t prdata;
    logic      pready;

    int fail_count;
    int pending;
    int samples_seen;
    int results_seen;
    int coef_writes;
    int coef_reads;
    int hold_len;
    bit idle_on;

    dafir_sample_if sample_bus ();
    dafir_result_if result_bus ();

    da_fir_filter_core #(
        .TAPS      (TAPS),
        .DATA_BITS (DATA_BITS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_bus),
        .result_ch (result_bus),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    da_fir_filter_check #(
        .TAPS (TAPS)
    ) u_filter_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .smp          (sample_bus),
        .res          (result_bus),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .samples_seen (samples_seen),
        .results_seen (results_seen)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    initial
    begin
        #10_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    // result side: random stalls, or a long hold-off when asked
    initial
    begin
        result_bus.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_len > 0)
            begin
                result_bus.ready <= 1'b0;
                hold_len = hold_len - 1;
            end
            else
            begin
                result_bus.ready <= !(idle_on && $urandom_range(99) < 25);
            end
        end
    end

    task automatic offer_sample(input sample_t value);
        @(negedge clk);
        while (idle_on && $urandom_range(99) < 25)
        begin
            sample_bus.valid <= 1'b0;
            @(negedge clk);
        end
        sample_bus.valid  <= 1'b1;
        sample_bus.sample <= value;
        do @(posedge clk); while (sample_bus.ready !== 1'b1);
    endtask

    task automatic end_burst();
        @(negedge clk);
        sample_bus.valid <= 1'b0;
    endtask

    task automatic settle();
        end_burst();
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic wait_table_sweep();
        repeat (2) @(posedge clk);
        while (sample_bus.ready !== 1'b1) @(posedge clk);
    endtask

    task automatic write_coef(input int idx, input coef_t value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= apb_addr_t'(idx * 4);
        pwdata  <= {16'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        coef_writes++;
        wait_table_sweep();
    endtask

    task automatic read_coef(input int idx);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= apb_addr_t'(idx * 4);
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        coef_reads++;
    endtask

    task automatic load_coefs(input coef_t values [NUM_COEF]);
        for (int k = 0; k < NUM_COEF; k++)
        begin
            write_coef(k, values[k]);
        end
        for (int k = 0; k < NUM_COEF; k++)
        begin
            if ($urandom_range(1)) read_coef(k);
        end
    endtask

    function automatic coef_t pick_coef();
        case ($urandom_range(5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return '0;
            default: return coef_t'($urandom);
        endcase
    endfunction

    function automatic sample_t pick_sample();
        case ($urandom_range(7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return sample_t'($urandom_range(15)) - sample_t'(8);
            default: return sample_t'($urandom);
        endcase
    endfunction

    initial
    begin
        coef_t   coef_set [NUM_COEF];
        sample_t impulse_run [11];

        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        sample_bus.valid  = 1'b0;
        sample_bus.sample = '0;
        idle_on           = 1'b1;
        hold_len          = 0;
        coef_writes       = 0;
        coef_reads        = 0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait_table_sweep();

        // coefficients still at reset
        offer_sample(16'sh7fff);
        offer_sample(16'sh8000);
        settle();

        // most negative coefficients and samples, largest sum
        foreach (coef_set[k]) coef_set[k] = 16'sh8000;
        load_coefs(coef_set);
        repeat (8) offer_sample(16'sh8000);
        settle();

        // impulse through mixed coefficients
        coef_set = '{16'sh7fff, 16'sh8000, 16'sh0001, 16'shffff,
                     16'sh5555, 16'shaaaa, 16'sh0000, 16'sh3039};
        load_coefs(coef_set);
        impulse_run = '{16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000,
                        16'sh0000, 16'sh0000, 16'sh0000, 16'sh7fff, 16'shffff,
                        16'sh8000};
        foreach (impulse_run[i]) offer_sample(impulse_run[i]);
        settle();

        for (int p = 0; p < RAND_PHASES; p++)
        begin
            if (p == 0)
            begin
                foreach (coef_set[k]) coef_set[k] = 16'sh7fff;
            end
            else
            begin
                foreach (coef_set[k]) coef_set[k] = pick_coef();
            end
            load_coefs(coef_set);
            idle_on = (p != 3);
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 5 && i == 10) hold_len = 300;
                if (p == 6 && i == 45)
                begin
                    end_burst();
                    wait (pending == 0);
                end
                offer_sample(pick_sample());
            end
            settle();
        end
        idle_on = 1'b1;

        $display("run covered %0d samples and %0d filtered words over %0d coefficient sets",
                 samples_seen, results_seen, RAND_PHASES + 3);
        $display("%0d coefficient writes, %0d read backs", coef_writes, coef_reads);
        if (fail_count == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
